// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every edge outside reset.
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define SFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sfr_pkg.sv -----
// Types and constants of the frame receiver: beat layouts, frame geometry and register map.
// Used by the top level and by its checker; depends on nothing else.
`timescale 1ns / 1ps

package sfr_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
        logic       rx_error;
    } t_in_beat;

    typedef struct packed {
        logic [4:0]  channel_index;
        logic [10:0] channel_value;
        logic        failsafe;
        logic        last;
    } t_out_beat;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    localparam logic [7:0] SYNC_VALUE = 8'h0F;

    // Frame slots: 0 is the header, 1..22 carry channel bits, 23 the flags, 24 the trailer.
    localparam logic [4:0] SLOT_HEADER     = 5'd0;
    localparam logic [4:0] SLOT_FIRST_DATA = 5'd1;
    localparam logic [4:0] SLOT_LAST_DATA  = 5'd22;
    localparam logic [4:0] SLOT_FLAGS      = 5'd23;
    localparam logic [4:0] SLOT_TRAILER    = 5'd24;
    localparam int         STORE_DEPTH     = 22;

    localparam int         FLAG_DIG0 = 0;
    localparam int         FLAG_DIG1 = 1;
    localparam int         FLAG_LOSS = 2;
    localparam int         FLAG_FS   = 3;

    localparam logic [4:0] CHAN_DIG0 = 5'd16;
    localparam logic [4:0] CHAN_DIG1 = 5'd17;

    localparam logic [7:0] MS_MAX = 8'd255;

    // Register map, indexed by paddr[3:2].
    localparam logic [1:0] REG_SYNC_GAP     = 2'd0;
    localparam logic [1:0] REG_FAILSAFE     = 2'd1;
    localparam logic [1:0] REG_DIGITAL_LOW  = 2'd2;
    localparam logic [1:0] REG_DIGITAL_HIGH = 2'd3;

    localparam logic [7:0]  RST_SYNC_GAP     = 8'd3;
    localparam logic [7:0]  RST_FAILSAFE     = 8'd100;
    localparam logic [10:0] RST_DIGITAL_LOW  = 11'd172;
    localparam logic [10:0] RST_DIGITAL_HIGH = 11'd1812;

endpackage

// ----- hw/rtl/sbus_frame_receiver_top.sv -----
// Frame receiver top level: byte intake, frame store memory and channel report engine.
// Depends on sfr_pkg for the beat structs, frame geometry and register map.
`timescale 1ns / 1ps

// The block takes one beat per cycle on the input channel: either a received UART
// byte with its error flag, or a one millisecond tick. Bytes are gathered into
// 25-byte frames after a sync byte that follows a quiet gap longer than the sync_gap_ms
// register. Every completed frame with a good header produces a report of 18 output
// beats: channels 0 to 15 unpacked eleven bits at a time from the stored payload, then
// the two digital channels, with last set on channel 17. A completion that comes when
// the millisecond count has reached the failsafe limit register reports the stored
// frame with failsafe set and drops sync. The payload bytes live in a 22-entry
// synchronous memory; a report reads it one entry at a time (read, then merge into a
// bit accumulator), and it waits while a new channel meets a stalled output. During a
// report the input channel stalls byte beats so the store cannot change under the
// reader; tick beats are still taken every cycle. Outside a report every beat is taken
// in the cycle it is offered, and a finished output beat waits in its own register
// without holding up the input.
// There is no clearing pass after reset: each memory entry has a valid bit and reads as
// zero until first written. The APB port holds four registers at byte addresses 0, 4,
// 8 and 12; writes are to be made while no report is running.
module sbus_frame_receiver_top (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sfr_pkg::t_in_beat  i_in_data,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sfr_pkg::t_out_beat o_out_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Report engine states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_MERGE = 3'd2;
    localparam logic [2:0] S_DIG0  = 3'd3;
    localparam logic [2:0] S_DIG1  = 3'd4;

    // Configuration registers.
    logic [7:0]  r_sync_gap;
    logic [7:0]  r_fs_limit;
    logic [10:0] r_dig_low;
    logic [10:0] r_dig_high;

    // Receiver state. The header slot is kept only as "holds the sync value",
    // the flag slot as a register, and the trailer is never read so it is not kept.
    logic        r_in_sync,   n_in_sync;
    logic [4:0]  r_pos,       n_pos;
    logic [7:0]  r_ms,        n_ms;
    logic        r_head_ok,   n_head_ok;
    logic [7:0]  r_flags,     n_flags;

    // Payload store for slots 1..22, with a valid bit per entry.
    logic [7:0]  r_store [0:sfr_pkg::STORE_DEPTH-1];
    logic [sfr_pkg::STORE_DEPTH-1:0] r_store_vld;
    logic [7:0]  r_rd_data;
    logic        r_rd_vld;

    // Report engine.
    logic [2:0]  r_state,     n_state;
    logic [4:0]  r_rd_ptr,    n_rd_ptr;
    logic [17:0] r_acc,       n_acc;
    logic [3:0]  r_acc_cnt,   n_acc_cnt;
    logic [4:0]  r_ch,        n_ch;
    logic        r_timeout,   n_timeout;

    // Output register.
    logic                r_out_valid, n_out_valid;
    sfr_pkg::t_out_beat  r_out,       n_out;

    logic        busy;
    logic        in_fire;
    logic        is_byte;
    logic [4:0]  eff_pos;
    logic        head_now;
    logic        completion;
    logic        timed_out;
    logic        start_report;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic        rd_en;
    logic        out_free;
    logic        fs_flag;
    logic [7:0]  merge_byte;
    logic [17:0] merged;
    logic [4:0]  cnt_sum;
    logic        cfg_wr;

    assign busy       = (r_state != S_IDLE);
    assign o_in_stall = busy && (i_in_data.cmd == sfr_pkg::CMD_BYTE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign is_byte    = (i_in_data.cmd == sfr_pkg::CMD_BYTE) && !i_in_data.rx_error;

    // While hunting every byte lands in the header slot.
    assign eff_pos    = r_in_sync ? r_pos : sfr_pkg::SLOT_HEADER;
    assign head_now   = (eff_pos == sfr_pkg::SLOT_HEADER)
                        ? (i_in_data.rx_byte == sfr_pkg::SYNC_VALUE) : r_head_ok;
    assign completion = !r_in_sync || (eff_pos == sfr_pkg::SLOT_TRAILER);
    assign timed_out  = (r_ms >= r_fs_limit);

    assign wr_en  = in_fire && is_byte
                    && (eff_pos >= sfr_pkg::SLOT_FIRST_DATA)
                    && (eff_pos <= sfr_pkg::SLOT_LAST_DATA);
    assign wr_idx = eff_pos - sfr_pkg::SLOT_FIRST_DATA;

    // Intake of one beat: tick counter, error handling, slot writes, frame completion.
    always_comb begin
        n_in_sync    = r_in_sync;
        n_pos        = r_pos;
        n_ms         = r_ms;
        n_head_ok    = r_head_ok;
        n_flags      = r_flags;
        start_report = 1'b0;
        n_timeout    = r_timeout;

        if (in_fire) begin
            if (i_in_data.cmd == sfr_pkg::CMD_TICK) begin
                if (r_ms != sfr_pkg::MS_MAX) begin
                    n_ms = r_ms + 8'd1;
                end
            end else if (i_in_data.rx_error) begin
                n_in_sync = 1'b0;
                n_head_ok = 1'b0;
                n_pos     = sfr_pkg::SLOT_HEADER;
            end else begin
                if (eff_pos == sfr_pkg::SLOT_HEADER) begin
                    n_head_ok = head_now;
                end
                if (eff_pos == sfr_pkg::SLOT_FLAGS) begin
                    n_flags = i_in_data.rx_byte;
                end

                if (!completion) begin
                    n_pos = eff_pos + 5'd1;
                end else begin
                    n_ms = 8'd0;
                    if (timed_out) begin
                        // Late frame: report what is stored, flagged, and hunt again.
                        start_report = 1'b1;
                        n_timeout    = 1'b1;
                        n_in_sync    = 1'b0;
                        n_head_ok    = 1'b0;
                        n_pos        = sfr_pkg::SLOT_HEADER;
                    end else if (r_in_sync && head_now) begin
                        start_report = 1'b1;
                        n_timeout    = 1'b0;
                        n_head_ok    = 1'b0;
                        n_pos        = sfr_pkg::SLOT_HEADER;
                    end else if (!r_in_sync && (r_ms > r_sync_gap) && head_now) begin
                        n_in_sync = 1'b1;
                        n_pos     = sfr_pkg::SLOT_FIRST_DATA;
                    end else begin
                        n_in_sync = 1'b0;
                        n_head_ok = 1'b0;
                        n_pos     = sfr_pkg::SLOT_HEADER;
                    end
                end
            end
        end
    end

    // Report engine: walk the payload entries, merge each byte into the bit
    // accumulator and hand out one channel whenever eleven bits are present, then the two digital channels.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fs_flag    = r_timeout || r_flags[sfr_pkg::FLAG_LOSS] || r_flags[sfr_pkg::FLAG_FS];
    assign merge_byte = r_rd_vld ? r_rd_data : 8'd0;
    assign merged     = r_acc | ({10'd0, merge_byte} << r_acc_cnt);
    assign cnt_sum    = {1'b0, r_acc_cnt} + 5'd8;
    assign rd_en      = (r_state == S_READ);

    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_acc       = r_acc;
        n_acc_cnt   = r_acc_cnt;
        n_ch        = r_ch;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (start_report) begin
                    n_state   = S_READ;
                    n_rd_ptr  = 5'd0;
                    n_acc     = 18'd0;
                    n_acc_cnt = 4'd0;
                    n_ch      = 5'd0;
                end
            end
            S_READ: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (cnt_sum >= 5'd11) begin
                    if (out_free) begin
                        n_out_valid               = 1'b1;
                        n_out.channel_index       = r_ch;
                        n_out.channel_value       = merged[10:0];
                        n_out.failsafe            = fs_flag;
                        n_out.last                = 1'b0;
                        n_acc                     = merged >> 11;
                        n_acc_cnt                 = 4'(cnt_sum - 5'd11);
                        n_ch                      = r_ch + 5'd1;
                        n_rd_ptr                  = r_rd_ptr + 5'd1;
                        n_state = (r_rd_ptr == 5'(sfr_pkg::STORE_DEPTH - 1)) ? S_DIG0 : S_READ;
                    end
                end else begin
                    n_acc     = merged;
                    n_acc_cnt = cnt_sum[3:0];
                    n_rd_ptr  = r_rd_ptr + 5'd1;
                    n_state   = S_READ;
                end
            end
            S_DIG0: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.channel_index = sfr_pkg::CHAN_DIG0;
                    n_out.channel_value = r_flags[sfr_pkg::FLAG_DIG0] ? r_dig_high : r_dig_low;
                    n_out.failsafe      = fs_flag;
                    n_out.last          = 1'b0;
                    n_state             = S_DIG1;
                end
            end
            S_DIG1: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.channel_index = sfr_pkg::CHAN_DIG1;
                    n_out.channel_value = r_flags[sfr_pkg::FLAG_DIG1] ? r_dig_high : r_dig_low;
                    n_out.failsafe      = fs_flag;
                    n_out.last          = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sync   <= 1'b0;
            r_pos       <= sfr_pkg::SLOT_HEADER;
            r_ms        <= 8'd0;
            r_head_ok   <= 1'b0;
            r_flags     <= 8'd0;
            r_store_vld <= '0;
            r_state     <= S_IDLE;
            r_rd_ptr    <= 5'd0;
            r_acc_cnt   <= 4'd0;
            r_ch        <= 5'd0;
            r_timeout   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_sync   <= n_in_sync;
            r_pos       <= n_pos;
            r_ms        <= n_ms;
            r_head_ok   <= n_head_ok;
            r_flags     <= n_flags;
            if (wr_en) begin
                r_store_vld[wr_idx] <= 1'b1;
            end
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_acc_cnt   <= n_acc_cnt;
            r_ch        <= n_ch;
            r_timeout   <= n_timeout;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_out <= n_out;
    end

    // Frame store memory: one write port from the intake, one registered read port
    // for the report engine. Byte beats stall during a report, so the two never meet.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_idx] <= i_in_data.rx_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_store[r_rd_ptr];
            r_rd_vld  <= r_store_vld[r_rd_ptr];
        end
    end

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_gap <= sfr_pkg::RST_SYNC_GAP;
            r_fs_limit <= sfr_pkg::RST_FAILSAFE;
            r_dig_low  <= sfr_pkg::RST_DIGITAL_LOW;
            r_dig_high <= sfr_pkg::RST_DIGITAL_HIGH;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                sfr_pkg::REG_SYNC_GAP:     r_sync_gap <= pwdata[7:0];
                sfr_pkg::REG_FAILSAFE:     r_fs_limit <= pwdata[7:0];
                sfr_pkg::REG_DIGITAL_LOW:  r_dig_low  <= pwdata[10:0];
                sfr_pkg::REG_DIGITAL_HIGH: r_dig_high <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sfr_pkg::REG_SYNC_GAP:     prdata = {24'd0, r_sync_gap};
            sfr_pkg::REG_FAILSAFE:     prdata = {24'd0, r_fs_limit};
            sfr_pkg::REG_DIGITAL_LOW:  prdata = {21'd0, r_dig_low};
            sfr_pkg::REG_DIGITAL_HIGH: prdata = {21'd0, r_dig_high};
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hw/rtl/sfr_checker.sv -----
// Port-level checker for the frame receiver, bound to the top level below.
// Depends on sfr_pkg and on the macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input sfr_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sfr_pkg::t_out_beat o_out_data
);

    // A waiting output beat stays offered until it is taken.
    `SFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "output beat dropped while stalled")

    // A waiting output beat does not change.
    `SFR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data), "output beat changed while stalled")

    // Last marks exactly the final digital channel.
    `SFR_ASSERT_NOW(a_last_chan, i_clk, i_rst_n, o_out_valid, o_out_data.last == (o_out_data.channel_index == sfr_pkg::CHAN_DIG1), "last does not match channel 17")

    // While a report is still in progress, byte beats are held off the frame store.
    `SFR_ASSERT_NOW(a_store_interlock, i_clk, i_rst_n, o_out_valid && !o_out_data.last && i_in_valid && (i_in_data.cmd == sfr_pkg::CMD_BYTE), o_in_stall, "byte taken during a report")

endmodule

bind sbus_frame_receiver_top sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
